// ===== hdl/windowed_rms_meter_defines.svh =====
// ----------------------------------------------------------------------------
// windowed_rms_meter_defines.svh
// Assertion macros used by the checker of the RMS meter.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RMS_METER_DEFINES_SVH
`define WINDOWED_RMS_METER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define WRMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("windowed_rms_meter: assertion failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define WRMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("windowed_rms_meter: assertion failed");

`endif

// ===== hdl/wrms_pkg.sv =====
// ----------------------------------------------------------------------------
// wrms_pkg
// Widths, step counts and shared types of the windowed RMS meter.
// ----------------------------------------------------------------------------
package wrms_pkg;

  // Port field width and the number of sample bits that take part.
  localparam int DATA_W      = 16;
  localparam int SAMPLE_BITS = 16;

  // Square of one sample, running sum, divisor, remainder and quotient.
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int SUM_W  = 64;
  localparam int DVS_W  = DATA_W + 1;
  localparam int REM_W  = DATA_W;
  localparam int QUO_W  = 32;

  // Root and the partial remainder of the root unit.
  localparam int RMS_W     = QUO_W / 2;
  localparam int SQ_REM_W  = RMS_W + 3;

  localparam int SQ_CNT_W   = $clog2(SAMPLE_BITS + 1);
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int ROOT_CNT_W = $clog2(RMS_W + 1);

  // Status that each serial unit reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== hdl/wrms_sq.sv =====
// ----------------------------------------------------------------------------
// wrms_sq
// Shift-and-add squarer: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wrms_sq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [wrms_pkg::SAMPLE_BITS-1:0]    operand,
  output logic [wrms_pkg::PROD_W-1:0]         product,
  output wrms_pkg::unit_stat_t                stat
);
  import wrms_pkg::*;

  logic [PROD_W-1:0]      mcand_r;
  logic [PROD_W-1:0]      acc_r;
  logic [SAMPLE_BITS-1:0] mplier_r;
  logic [SQ_CNT_W-1:0]    cnt_r;
  logic                   busy_r;
  logic                   done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SQ_CNT_W'(SAMPLE_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - SQ_CNT_W'(1);
        if (cnt_r == SQ_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= PROD_W'(operand);
      mplier_r <= operand;
      acc_r    <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign product = acc_r;
  assign stat    = '{busy: busy_r, done: done_r};

endmodule

// ===== hdl/wrms_div.sv =====
// ----------------------------------------------------------------------------
// wrms_div
// Restoring divider: one dividend bit per cycle, low quotient bits kept.
// ----------------------------------------------------------------------------
module wrms_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wrms_pkg::SUM_W-1:0]    dividend,
  input  logic [wrms_pkg::DVS_W-1:0]    divisor,
  output logic [wrms_pkg::QUO_W-1:0]    quotient,
  output wrms_pkg::unit_stat_t          stat
);
  import wrms_pkg::*;

  logic [SUM_W-1:0]     dvd_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [REM_W-1:0]     rem_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DVS_W-1:0]     trial;
  logic [DVS_W-1:0]     diff;
  logic                 ge;

  // The remainder stays below the divisor, so it fits the sample width.
  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign diff  = trial - dvs_r;
  assign ge    = (trial >= dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign quotient = quo_r;
  assign stat     = '{busy: busy_r, done: done_r};

endmodule

// ===== hdl/wrms_sqrt.sv =====
// ----------------------------------------------------------------------------
// wrms_sqrt
// Restoring square root: two radicand bits in, one root bit out per cycle.
// ----------------------------------------------------------------------------
module wrms_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wrms_pkg::QUO_W-1:0]    radicand,
  output logic [wrms_pkg::RMS_W-1:0]    root,
  output wrms_pkg::unit_stat_t          stat
);
  import wrms_pkg::*;

  logic [QUO_W-1:0]      rad_r;
  logic [SQ_REM_W-1:0]   rem_r;
  logic [RMS_W-1:0]      root_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [SQ_REM_W-1:0]   part;
  logic [SQ_REM_W-1:0]   trial;
  logic                  ge;

  // The remainder never exceeds twice the root, so its top two bits are zero.
  assign part  = {rem_r[SQ_REM_W-3:0], rad_r[QUO_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = (part >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ROOT_CNT_W'(RMS_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - ROOT_CNT_W'(1);
        if (cnt_r == ROOT_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? (part - trial) : part;
      root_r <= {root_r[RMS_W-2:0], ge};
    end
  end

  assign root = root_r;
  assign stat = '{busy: busy_r, done: done_r};

endmodule

// ===== hdl/windowed_rms_meter.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_meter
// Per-window RMS meter built from bit-serial square, divide and root units.
// ----------------------------------------------------------------------------
// Each input item carries one sample. It is squared and added to a running
// 64-bit sum that only reset clears, and the sample is counted. When the count
// reaches cfg_window_length (0 means 65536), the sum is divided by the window
// length, the root of the low 32 quotient bits becomes the held RMS value and
// the count restarts. Every item gives one result item: the held RMS value
// and out_window_done, set when that item closed a window.
// The squarer takes one sample bit per cycle. An item that closes a window
// then passes a setup state that starts the divider, the divider itself (one
// bit of the 64-bit sum per cycle) and the root unit (one root bit per cycle)
// before its result is loaded. One item is in work at a time, and the next
// item can be taken in the cycle after a result is loaded. The result sits
// in an output register, so the next item is taken while the receiver
// stalls; a finished result then waits until out_ready frees the register.
// Reset clears count, sum and value and sets the window length to 1.
// cfg_ready is always high; write only while idle.
// ----------------------------------------------------------------------------
module windowed_rms_meter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wrms_pkg::DATA_W-1:0]   in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wrms_pkg::DATA_W-1:0]   out_rms_value,
  output logic                          out_window_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wrms_pkg::DATA_W-1:0]   cfg_window_length
);
  import wrms_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]        state_r;
  logic [DATA_W-1:0] wlen_r;
  logic [DATA_W-1:0] count_r;
  logic [SUM_W-1:0]  sum_r;
  logic [RMS_W-1:0]  rms_r;
  logic              win_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_rms_r;
  logic              out_done_r;

  logic              sq_start;
  logic              div_start;
  logic              root_start;
  logic [PROD_W-1:0] square;
  logic [QUO_W-1:0]  quot;
  logic [RMS_W-1:0]  root;
  logic [DATA_W-1:0] count_nxt;
  logic              out_load;
  unit_stat_t        sq_stat;
  unit_stat_t        div_stat;
  unit_stat_t        root_stat;

  assign in_ready   = (state_r == S_IDLE) && !sq_stat.busy;
  assign cfg_ready  = 1'b1;
  assign sq_start   = in_valid && in_ready;
  assign div_start  = (state_r == S_ACC);
  assign root_start = (state_r == S_DIV) && div_stat.done;
  assign count_nxt  = count_r + DATA_W'(1);
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_ready);

  wrms_sq u_sq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (in_sample[SAMPLE_BITS-1:0]),
    .product (square),
    .stat    (sq_stat)
  );

  // A zero register value stands for a window of 65536 samples.
  wrms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  ({(wlen_r == '0), wlen_r}),
    .quotient (quot),
    .stat     (div_stat)
  );

  wrms_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (quot),
    .root     (root),
    .stat     (root_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wlen_r      <= DATA_W'(1);
      count_r     <= '0;
      sum_r       <= '0;
      rms_r       <= '0;
      win_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        wlen_r <= cfg_window_length;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (sq_start) begin
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_stat.done) begin
            sum_r <= sum_r + SUM_W'(square);
            if (count_nxt == wlen_r) begin
              count_r <= '0;
              win_r   <= 1'b1;
              state_r <= S_ACC;
            end else begin
              count_r <= count_nxt;
              win_r   <= 1'b0;
              state_r <= S_OUT;
            end
          end
        end
        S_ACC: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_stat.done) begin
            rms_r   <= root;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rms_r  <= DATA_W'(rms_r);
      out_done_r <= win_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rms_value   = out_rms_r;
  assign out_window_done = out_done_r;

endmodule

// ===== hdl/windowed_rms_meter_checker.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_meter_checker
// Port-level checks of the RMS meter, bound to every instance of the block.
// ----------------------------------------------------------------------------
`include "windowed_rms_meter_defines.svh"

module windowed_rms_meter_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_sample,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_rms_value,
  input logic        out_window_done,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_window_length
);

  // A stalled result keeps its payload.
  `WRMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_rms_value) && $stable(out_window_done))

  // Only one item is in work, so an accepted item closes the input side.
  `WRMS_ASSERT_NEXT(a_one_in_work, in_valid && in_ready, !in_ready)

  // No result can appear in the cycle right after an item is taken.
  `WRMS_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && !out_valid, !out_valid)

  // The configuration port never stalls.
  `WRMS_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind windowed_rms_meter windowed_rms_meter_checker u_checker (.*);

// ===== tb/sv/tb_windowed_rms_meter.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_rms_meter
// Self-checking bench for the windowed RMS meter.
// ----------------------------------------------------------------------------
// Samples go in through a bursty sender, and results leave through a receiver
// that stalls in patterns. An in-bench model squares, accumulates, divides
// and roots each accepted sample. Every result item is then checked against
// the oldest pending prediction. The window length is changed only while the
// block is idle. The run covers the reset length, the register extremes, a
// length lowered below the running count, and random windows and samples.
// ----------------------------------------------------------------------------
module tb_windowed_rms_meter;
  timeunit 1ns;
  timeprecision 1ps;

  import wrms_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int TAIL_CYCLES  = 120;

  typedef struct packed {
    logic [DATA_W-1:0] rms;
    logic              done;
  } rms_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_sample = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_rms_value;
  logic              out_window_done;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DATA_W-1:0] cfg_window_length = '0;

  // Model state, kept in step with every accepted item.
  logic [15:0] win_len;
  logic [15:0] acc_count;
  logic [63:0] acc_sum;
  logic [15:0] cur_rms;

  rms_result_t pending_rms_q[$];
  rms_result_t got_rms;
  int          err_count = 0;
  int          samples_sent = 0;
  int          windows_seen = 0;
  int          lengths_written = 0;
  int          quiet_cycles = 0;

  // Traffic shaping, changed from phase to phase.
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int burst_left = 0;
  int stall_left = 0;

  windowed_rms_meter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rms_value     (out_rms_value),
    .out_window_done   (out_window_done),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length)
  );

  always #1 clk = ~clk;

  // Floor square root by trying each root bit from the top down.
  function automatic logic [15:0] floor_root(logic [31:0] v);
    logic [15:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      t = {16'd0, r | (16'd1 << b)};
      if (t * t <= v) r = t[15:0];
    end
    return r;
  endfunction

  function automatic rms_result_t predict_rms(logic [15:0] s);
    rms_result_t res;
    logic [63:0] divisor;
    logic [63:0] quot;
    res.done = 1'b0;
    acc_sum = acc_sum + ({48'd0, s} * {48'd0, s});
    acc_count = acc_count + 16'd1;
    if (acc_count == win_len) begin
      // A length of zero stands for a full 16-bit wrap of the count.
      divisor = (win_len == 16'd0) ? 64'd65536 : {48'd0, win_len};
      quot = acc_sum / divisor;
      cur_rms = floor_root(quot[31:0]);
      acc_count = '0;
      res.done = 1'b1;
    end
    res.rms = cur_rms;
    return res;
  endfunction

  // Scoreboard: configuration first, then results, then new samples.
  always @(posedge clk) begin
    if (!rst_n) begin
      win_len = 16'd1;
      acc_count = '0;
      acc_sum = '0;
      cur_rms = '0;
    end else begin
      if (cfg_valid && cfg_ready) win_len = cfg_window_length;
      if (out_valid && out_ready) begin
        if (pending_rms_q.size() == 0) begin
          $error("unexpected result item: rms_value %0d window_done %0d",
                 out_rms_value, out_window_done);
          err_count++;
        end else begin
          got_rms = pending_rms_q.pop_front();
          if (out_rms_value !== got_rms.rms) begin
            $error("rms_value: expected %0d, got %0d", got_rms.rms, out_rms_value);
            err_count++;
          end
          if (out_window_done !== got_rms.done) begin
            $error("window_done: expected %0d, got %0d", got_rms.done, out_window_done);
            err_count++;
          end
          if (got_rms.done) windows_seen++;
        end
      end
      if (in_valid && in_ready) pending_rms_q.push_back(predict_rms(in_sample));
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: ready between stalls of random length, started at rx_stall_pct.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < rx_stall_pct) stall_left <= $urandom_range(1, 40);
    end
  end

  task automatic send_sample(logic [15:0] s);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 99) < tx_gap_pct) ? $urandom_range(1, 30) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Hold the sender back until every predicted result has come out.
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rms_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] len);
    wait_results_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_window_length <= len;
    do @(posedge clk); while (!cfg_ready);
    lengths_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      3: return 16'd1 << $urandom_range(0, 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // Window of one after reset: every item closes a window, and two full-scale
  // squares already push the quotient past 32 bits.
  task automatic test_unit_window();
    tx_gap_pct = 30;
    rx_stall_pct = 20;
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h8000);
    wait_results_drained();
  endtask

  // Largest length, the zero length and a length below the running count.
  // None of them closes a window, then a length above the count does.
  task automatic test_extreme_lengths();
    write_window(16'hFFFF);
    repeat (3) send_sample(16'hFFFF);
    write_window(16'h0000);
    repeat (2) send_sample(16'h7FFF);
    write_window(16'd3);
    repeat (2) send_sample(16'h5555);
    write_window(16'd9);
    send_sample(16'hAAAA);
    send_sample(16'h0000);
    wait_results_drained();
  endtask

  task automatic test_random_windows();
    int          r;
    int          w;
    int          n;
    int          start;
    logic [15:0] cnt;
    start = samples_sent;
    while (samples_sent - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      case ($urandom_range(0, 3))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 5;
        2: rx_stall_pct = 25;
        default: rx_stall_pct = 60;
      endcase
      tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
      wait_results_drained();
      cnt = acc_count;
      if (r == 0) begin
        // A length far above the count: a few items, no window closes.
        w = ($urandom_range(0, 1) == 0) ? 0 : 65535;
        n = $urandom_range(1, 4);
      end else begin
        if (r < 12) w = $urandom_range(1, 8);
        else if (r < 18) w = $urandom_range(9, 64);
        else w = $urandom_range(65, 300);
        if (w <= cnt) w = cnt + $urandom_range(1, 8);
        n = (w - cnt) + $urandom_range(0, 2) * w + $urandom_range(0, 3);
      end
      // Keep the total close to the planned number of items.
      if (n > RANDOM_ITEMS - (samples_sent - start))
        n = RANDOM_ITEMS - (samples_sent - start);
      write_window(16'(w));
      for (int i = 0; i < n; i++) begin
        send_sample(pick_sample());
        if ($urandom_range(0, 199) == 0) wait_results_drained();
      end
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unit_window();
    test_extreme_lengths();
    test_random_windows();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d samples and %0d closed windows over %0d window lengths,",
             samples_sent, windows_seen, lengths_written);
    $display("including the largest and zero lengths and a length below the count.");
    if (err_count == 0 && pending_rms_q.size() == 0) begin
      $display("status: pass");
    end else begin
      if (pending_rms_q.size() != 0)
        $error("%0d expected result items never arrived", pending_rms_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/wrms_pkg.sv
hdl/wrms_sq.sv
hdl/wrms_div.sv
hdl/wrms_sqrt.sv
hdl/windowed_rms_meter.sv
hdl/windowed_rms_meter_checker.sv
tb/sv/tb_windowed_rms_meter.sv
